// ===== sv/ftba_pkg.sv =====
`timescale 1ns / 1ps

package ftba_pkg;

  // The free-block bitmap is kept in words of this many bits.
  localparam int WORD_BITS  = 32;
  localparam int WORD_SHIFT = 5;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_EXISTS    = 3'd1,
    STATUS_NO_ENTRY  = 3'd2,
    STATUS_NO_BLOCK  = 3'd3,
    STATUS_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_BREAD,
    S_BSCAN,
    S_DREAD,
    S_DWRITE
  } state_t;

  // Lowest clear bit of a bitmap word: {found, position}.
  function automatic logic [WORD_SHIFT:0] first_zero(input logic [WORD_BITS-1:0] w);
    logic [WORD_SHIFT:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r = {1'b1, WORD_SHIFT'(i)};
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/file_table_block_allocator.sv =====
`timescale 1ns / 1ps

// File table with a free-block bitmap. Each item is a create, delete or lookup
// command for a 16-bit file id and gives exactly one result item (status, entry
// index, block number). The id and block of each table entry live in one RAM
// and the block bitmap in a second RAM of 32-bit words; in-use marks of the
// entries are flip-flops. A command first scans the entry RAM, one entry per
// cycle. A create then scans the bitmap word by word, in a read state and a
// scan state per word, up to the configured disk size; a delete adds a
// read-modify-write of one bitmap word. An unused command code answers
// "not found" without a scan. After reset the block clears the bitmap word by
// word (blocks 0 and 1 reserved) and accepts no item meanwhile. The disk size
// register may be written only while no command is in flight.
module file_table_block_allocator
  import ftba_pkg::*;
#(
  parameter int TABLE_ENTRIES   = 16,
  parameter int DISK_BLOCKS_MAX = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [15:0] file_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [3:0]  entry_index,
  output logic [8:0]  block_number
);

  localparam int EW    = $clog2(TABLE_ENTRIES);
  localparam int WORDS = (DISK_BLOCKS_MAX + WORD_BITS - 1) / WORD_BITS;
  localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BIW   = WW + WORD_SHIFT;
  localparam int IDW   = 16 + BIW;
  localparam int CW    = ($clog2(DISK_BLOCKS_MAX) + 2 > 11) ? $clog2(DISK_BLOCKS_MAX) + 2 : 11;

  state_t state, state_next;

  logic [9:0]           disk_blocks;
  logic [1:0]           cmd_r;
  logic [15:0]          id_r;
  logic [TABLE_ENTRIES-1:0] in_use;

  logic [EW:0]          ecnt;
  logic                 pend;
  logic [EW-1:0]        pidx;
  logic                 found;
  logic [EW-1:0]        found_idx;
  logic [BIW-1:0]       found_blk;
  logic                 free_ok;
  logic [EW-1:0]        free_idx;
  logic [WW-1:0]        wcnt;

  logic                 res_pend;
  logic [2:0]           res_status;
  logic [EW-1:0]        res_entry;
  logic [BIW-1:0]       res_block;

  // RAM ports.
  logic                 t_we;
  logic [IDW-1:0]       t_wdata, t_rdata;
  logic [EW-1:0]        t_raddr;
  logic                 b_we;
  logic [WW-1:0]        b_waddr, b_raddr;
  logic [WORD_BITS-1:0] b_wdata, b_rdata;

  // Scan and bitmap helpers.
  logic                 hit;
  logic                 accept;
  logic                 finish;
  logic [2:0]           fin_status;
  logic [EW-1:0]        fin_entry;
  logic [BIW-1:0]       fin_block;
  logic [CW-1:0]        limit, base, avail;
  logic [WORD_BITS-1:0] valid_mask, masked;
  logic [WORD_SHIFT:0]  fz;
  logic                 last_word;
  logic [BIW-1:0]       new_blk;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE) || res_pend;

  ftba_ram #(.WIDTH(IDW), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk  (clk),
    .we   (t_we),
    .waddr(free_idx),
    .wdata(t_wdata),
    .raddr(t_raddr),
    .rdata(t_rdata)
  );

  ftba_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_bitmap (
    .clk  (clk),
    .we   (b_we),
    .waddr(b_waddr),
    .wdata(b_wdata),
    .raddr(b_raddr),
    .rdata(b_rdata)
  );

  // Usable disk size and the bitmap word under test.
  always_comb begin
    limit = (CW'(disk_blocks) > CW'(DISK_BLOCKS_MAX)) ? CW'(DISK_BLOCKS_MAX)
                                                      : CW'(disk_blocks);
    base  = CW'(wcnt) << WORD_SHIFT;
    avail = (limit > base) ? (limit - base) : '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      valid_mask[j] = (CW'(j) < avail);
    end
    masked    = b_rdata | ~valid_mask;
    fz        = first_zero(masked);
    new_blk   = {wcnt, fz[WORD_SHIFT-1:0]};
    last_word = (base + CW'(WORD_BITS) >= limit) || (wcnt == WW'(WORDS - 1));
    hit       = pend && in_use[pidx] && (t_rdata[IDW-1 -: 16] == id_r);
  end

  // Sequencer: next state, RAM controls and the result of a command.
  always_comb begin
    state_next = state;
    t_raddr    = ecnt[EW-1:0];
    t_we       = 1'b0;
    t_wdata    = {id_r, new_blk};
    b_we       = 1'b0;
    b_waddr    = wcnt;
    b_raddr    = wcnt;
    b_wdata    = b_rdata | (WORD_BITS'(1) << fz[WORD_SHIFT-1:0]);
    finish     = 1'b0;
    fin_status = STATUS_NOT_FOUND;
    fin_entry  = '0;
    fin_block  = '0;
    unique case (state)
      S_CLEAR: begin
        b_we    = 1'b1;
        b_wdata = (wcnt == '0) ? WORD_BITS'(3) : '0;
        if (wcnt == WW'(WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (command == CMD_CREATE || command == CMD_DELETE || command == CMD_LOOKUP) begin
            state_next = S_SCAN;
          end else begin
            finish = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (hit || (pend && pidx == EW'(TABLE_ENTRIES - 1))) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (cmd_r)
          CMD_CREATE: begin
            if (found) begin
              finish     = 1'b1;
              fin_status = STATUS_EXISTS;
            end else if (!free_ok) begin
              finish     = 1'b1;
              fin_status = STATUS_NO_ENTRY;
            end else begin
              state_next = S_BREAD;
            end
          end
          CMD_DELETE: begin
            if (found) begin
              state_next = S_DREAD;
            end else begin
              finish = 1'b1;
            end
          end
          default: begin
            finish = 1'b1;
            if (found) begin
              fin_status = STATUS_OK;
              fin_entry  = found_idx;
              fin_block  = found_blk;
            end
          end
        endcase
        if (finish) begin
          state_next = S_IDLE;
        end
      end
      S_BREAD: begin
        state_next = S_BSCAN;
      end
      S_BSCAN: begin
        if (fz[WORD_SHIFT]) begin
          b_we       = 1'b1;
          t_we       = 1'b1;
          finish     = 1'b1;
          fin_status = STATUS_OK;
          fin_entry  = free_idx;
          fin_block  = new_blk;
          state_next = S_IDLE;
        end else if (last_word) begin
          finish     = 1'b1;
          fin_status = STATUS_NO_BLOCK;
          state_next = S_IDLE;
        end else begin
          state_next = S_BREAD;
        end
      end
      S_DREAD: begin
        b_raddr    = found_blk[BIW-1:WORD_SHIFT];
        state_next = S_DWRITE;
      end
      S_DWRITE: begin
        b_we       = 1'b1;
        b_waddr    = found_blk[BIW-1:WORD_SHIFT];
        b_wdata    = b_rdata & ~(WORD_BITS'(1) << found_blk[WORD_SHIFT-1:0]);
        finish     = 1'b1;
        fin_status = STATUS_OK;
        fin_entry  = found_idx;
        fin_block  = found_blk;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      disk_blocks <= 10'd512;
    end else if (cfg_valid && cfg_ready) begin
      disk_blocks <= cfg_data;
    end
  end

  // In-use marks of the entries.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else if (state == S_BSCAN && fz[WORD_SHIFT]) begin
      in_use[free_idx] <= 1'b1;
    end else if (state == S_DWRITE) begin
      in_use[found_idx] <= 1'b0;
    end
  end

  // Bitmap word counter, shared by the clearing pass and the block scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      wcnt <= '0;
    end else if (state == S_CLEAR) begin
      wcnt <= wcnt + WW'(1);
    end else if (state == S_DECIDE) begin
      wcnt <= '0;
    end else if (state == S_BSCAN) begin
      wcnt <= wcnt + WW'(1);
    end
  end

  // Entry scan: one read issued per cycle, compared in the cycle after.
  always_ff @(posedge clk) begin
    if (rst) begin
      ecnt    <= '0;
      pend    <= 1'b0;
      found   <= 1'b0;
      free_ok <= 1'b0;
    end else if (accept) begin
      ecnt    <= '0;
      pend    <= 1'b0;
      found   <= 1'b0;
      free_ok <= 1'b0;
    end else if (state == S_SCAN) begin
      if (ecnt < (EW + 1)'(TABLE_ENTRIES)) begin
        ecnt <= ecnt + (EW + 1)'(1);
        pend <= 1'b1;
      end else begin
        pend <= 1'b0;
      end
      if (hit && !found) begin
        found <= 1'b1;
      end
      if (pend && !in_use[pidx] && !free_ok) begin
        free_ok <= 1'b1;
      end
    end
  end

  // Scan payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= command;
      id_r  <= file_id;
    end
    if (state == S_SCAN) begin
      pidx <= ecnt[EW-1:0];
      if (hit && !found) begin
        found_idx <= pidx;
        found_blk <= t_rdata[BIW-1:0];
      end
      if (pend && !in_use[pidx] && !free_ok) begin
        free_idx <= pidx;
      end
    end
  end

  // Finished result waits here until the output register is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (finish) begin
        res_pend <= 1'b1;
      end else if (res_pend && (!out_valid || !out_stall)) begin
        res_pend <= 1'b0;
      end
      if (res_pend && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      res_status <= fin_status;
      res_entry  <= fin_entry;
      res_block  <= fin_block;
    end
    if (res_pend && (!out_valid || !out_stall)) begin
      status       <= res_status;
      entry_index  <= 4'(res_entry);
      block_number <= 9'(res_block);
    end
  end

endmodule

// ===== sv/ftba_ram.sv =====
`timescale 1ns / 1ps

module ftba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== verif/file_table_block_allocator_test.sv =====
`timescale 1ns / 1ps

module file_table_block_allocator_test;
  import ftba_pkg::*;

  localparam int NUM_ENTRIES = 16;
  localparam int NUM_BLOCKS  = 512;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] entry;
    logic [8:0] block;
  } answer_t;

  // Tracks the file table and block bitmap and queues the answer of each command.
  class alloc_tracker;
    bit          in_use[NUM_ENTRIES];
    logic [15:0] ids[NUM_ENTRIES];
    logic [8:0]  blocks[NUM_ENTRIES];
    bit          used[NUM_BLOCKS];
    int          disk_size;
    answer_t     pending[$];
    int          errors;

    function void clear_all();
      foreach (in_use[i]) in_use[i] = 0;
      foreach (used[i]) used[i] = 0;
      used[0] = 1;
      used[1] = 1;
      disk_size = 512;
      errors = 0;
    endfunction

    function int find_id(logic [15:0] id);
      for (int i = 0; i < NUM_ENTRIES; i++)
        if (in_use[i] && ids[i] == id) return i;
      return -1;
    endfunction

    // Note an accepted command and queue what it should answer.
    function void note_command(logic [1:0] cmd, logic [15:0] id);
      answer_t a;
      int e;
      int b;
      int lim;
      a = '{status: STATUS_NOT_FOUND, entry: 0, block: 0};
      lim = (disk_size > NUM_BLOCKS) ? NUM_BLOCKS : disk_size;
      if (cmd == CMD_CREATE) begin
        if (find_id(id) >= 0) begin
          a.status = STATUS_EXISTS;
        end else begin
          e = 0;
          while (e < NUM_ENTRIES && in_use[e]) e++;
          b = 0;
          while (b < lim && used[b]) b++;
          if (e >= NUM_ENTRIES) a.status = STATUS_NO_ENTRY;
          else if (b >= lim) a.status = STATUS_NO_BLOCK;
          else begin
            in_use[e] = 1;
            ids[e] = id;
            blocks[e] = b[8:0];
            used[b] = 1;
            a = '{status: STATUS_OK, entry: e[3:0], block: b[8:0]};
          end
        end
      end else if (cmd == CMD_DELETE || cmd == CMD_LOOKUP) begin
        e = find_id(id);
        if (e >= 0) begin
          a = '{status: STATUS_OK, entry: e[3:0], block: blocks[e]};
          if (cmd == CMD_DELETE) begin
            used[blocks[e]] = 0;
            in_use[e] = 0;
          end
        end
      end
      pending.push_back(a);
    endfunction

    // Compare one result item with the oldest expectation.
    function void check_answer(answer_t got);
      answer_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result item %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.entry !== want.entry) begin
        $display("%0t: entry expected %0d actual %0d", $time, want.entry, got.entry);
        errors++;
      end
      if (got.block !== want.block) begin
        $display("%0t: block expected %0d actual %0d", $time, want.block, got.block);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [9:0]  cfg_data = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  command = 0;
  logic [15:0] file_id = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [2:0]  status;
  logic [3:0]  entry_index;
  logic [8:0]  block_number;

  alloc_tracker tracker = new();
  bit           idle_free = 0;
  int           hold_cycles = 0;
  logic [15:0]  id_pool[8];

  file_table_block_allocator uut (.*);

  always #5 clk = ~clk;

  // Receiver: random stalls, plus long hold-offs on request.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_answer('{status: status, entry: entry_index, block: block_number});
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1;
    end else begin
      out_stall <= !idle_free && ($urandom_range(99) < 11);
    end
  end

  // Offer one command and wait until it is accepted. The block stalls its
  // input right after an accepted item, so the trailing edge costs nothing.
  task automatic send_command(logic [1:0] cmd, logic [15:0] id);
    while (!idle_free && $urandom_range(99) < 11) @(posedge clk);
    in_valid <= 1;
    command <= cmd;
    file_id <= id;
    do @(posedge clk); while (in_stall);
    tracker.note_command(cmd, id);
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_disk_size(logic [9:0] size);
    wait_drained();
    cfg_valid <= 1;
    cfg_data <= size;
    do @(posedge clk); while (!cfg_ready);
    tracker.disk_size = size;
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Mostly ids from a small pool so that creates, deletes and lookups meet.
  task automatic random_commands(int count);
    logic [1:0]  cmd;
    logic [15:0] id;
    for (int n = 0; n < count; n++) begin
      cmd = ($urandom_range(99) < 3) ? CMD_UNUSED : 2'($urandom_range(2));
      id = ($urandom_range(9) < 8) ? id_pool[$urandom_range(7)] : 16'($urandom);
      send_command(cmd, id);
    end
  endtask

  initial begin
    #20_000_000;
    $display("file_table_block_allocator_test: errors");
    $finish;
  end

  initial begin
    tracker.clear_all();
    foreach (id_pool[i]) id_pool[i] = 16'($urandom);
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    repeat (9) @(posedge clk);
    rst <= 0;

    // Directed: extremes of ids, every command, full table, tiny disk.
    send_command(CMD_LOOKUP, 16'h0000);
    send_command(CMD_CREATE, 16'h0000);
    send_command(CMD_CREATE, 16'h0000);
    send_command(CMD_CREATE, 16'hFFFF);
    send_command(CMD_LOOKUP, 16'hFFFF);
    send_command(CMD_DELETE, 16'h0000);
    send_command(CMD_DELETE, 16'h0000);
    send_command(CMD_UNUSED, 16'hFFFF);
    for (int i = 0; i < 16; i++) send_command(CMD_CREATE, 16'(16'h5550 + i));
    send_command(CMD_DELETE, 16'hFFFF);
    write_disk_size(10'd2);
    send_command(CMD_CREATE, 16'hAAAA);
    write_disk_size(10'd0);
    send_command(CMD_CREATE, 16'h1234);
    write_disk_size(10'd1023);
    send_command(CMD_CREATE, 16'h1234);
    for (int i = 0; i < 16; i++) send_command(CMD_DELETE, 16'(16'h5550 + i));
    send_command(CMD_DELETE, 16'h1234);

    // Random phases over two disk sizes.
    write_disk_size(10'd6);
    random_commands(300);
    write_disk_size(10'd513);
    random_commands(300);

    // Receiver holds off while the sender keeps offering.
    hold_cycles = 400;
    random_commands(100);

    // Sender pauses until everything has come back, then no idling at all.
    wait_drained();
    idle_free = 1;
    random_commands(200);
    idle_free = 0;
    write_disk_size(10'($urandom_range(3, 40)));
    random_commands(300);
    write_disk_size(10'd512);
    random_commands(320);

    wait_drained();
    if (tracker.errors == 0 && tracker.pending.size() == 0)
      $display("file_table_block_allocator_test: clean");
    else
      $display("file_table_block_allocator_test: errors");
    $finish;
  end

endmodule
